// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold at every edge where ante holds
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/mes_pkg.sv
// ----------------------------------------------------------------------------
// mes_pkg
// Types and constants of the Morse element sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mes_pkg;

    localparam int CODE_W    = 8;
    localparam int ELEM_W    = 7;
    localparam int CNT_W     = 3;
    localparam int DIT_W     = 11;
    localparam int DUR_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    localparam logic [DUR_W-1:0] DUR_MAX = 14'd8400;

    localparam logic [DIT_W-1:0] DIT_LENGTH_RST      = 11'd100;
    localparam logic             FARNSWORTH_MODE_RST = 1'b0;
    localparam logic [DUR_W-1:0] FARNSWORTH_GAP_RST  = 14'd720;

    localparam logic [CFG_IDX_W-1:0] CFG_DIT_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FARNSWORTH_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FARNSWORTH_GAP  = 2'd2;

    localparam logic FUNC_CODE = 1'b0;
    localparam logic FUNC_WORD = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
    } t_in_item;

    typedef struct packed {
        logic             tone_on;
        logic [DUR_W-1:0] duration;
        logic             last;
    } t_out_item;

    // classified item: elements left-aligned, current element in the MSB
    typedef struct packed {
        logic              word;
        logic [CNT_W-1:0]  count;
        logic [ELEM_W-1:0] bits;
    } t_desc;

    typedef struct packed {
        logic [DIT_W-1:0] dit_length;
        logic             farnsworth_mode;
        logic [DUR_W-1:0] farnsworth_gap;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// File: src/mes_front.sv
// ----------------------------------------------------------------------------
// mes_front
// Accepts input items, finds the sentinel and registers a descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_front import mes_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_item,
    output logic          o_desc_valid,
    output t_desc         o_desc,
    input  wire logic     i_q_full
);

    logic              r_valid;
    t_desc             r_desc;
    t_desc             n_desc;
    logic [CNT_W-1:0]  top;
    logic [CNT_W-1:0]  shamt;
    logic              accept;
    logic              drain;

    assign drain  = r_valid && !i_q_full;
    assign o_full = r_valid && i_q_full;
    assign accept = i_push && !o_full;

    always_comb begin
        top = '0;
        for (int i = 1; i < CODE_W; i++) begin
            if (i_item.code[i]) begin
                top = CNT_W'(i);
            end
        end
        shamt        = CNT_W'(ELEM_W) - top;
        n_desc.word  = (i_item.func == FUNC_WORD);
        n_desc.count = top;
        n_desc.bits  = i_item.code[ELEM_W-1:0] << shamt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

endmodule

`default_nettype wire

// File: src/mes_queue.sv
// ----------------------------------------------------------------------------
// mes_queue
// Small descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_queue import mes_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output t_desc      o_desc,
    output t_q_stat    o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == CNT_W_Q'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    assign o_desc = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: src/mes_back.sv
// ----------------------------------------------------------------------------
// mes_back
// Steps through a descriptor and emits one key segment per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_back import mes_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_q_stat i_q_stat,
    input  wire t_desc   i_desc,
    output logic         o_q_pop,
    output logic         o_empty,
    input  wire logic    i_pop,
    output t_out_item    o_result
);

    logic              r_busy;
    logic              r_word;
    logic [CNT_W-1:0]  r_cnt;
    logic [ELEM_W-1:0] r_bits;
    logic              r_space;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [DUR_W-1:0]  dit_dur;
    logic [DUR_W-1:0]  dah_dur;
    logic [DUR_W:0]    word_raw;
    logic [DUR_W-1:0]  word_dur;
    logic [DUR_W-1:0]  gap_dur;
    t_out_item         seg;
    logic              seg_done;
    logic              out_free;
    logic              load;
    logic              emit;

    assign dit_dur  = DUR_W'(i_cfg.dit_length);
    assign dah_dur  = {2'b0, i_cfg.dit_length, 1'b0} + dit_dur;
    assign word_raw = {1'b0, i_cfg.dit_length, 3'b0} - {4'b0, i_cfg.dit_length};
    assign word_dur = (word_raw > (DUR_W+1)'(DUR_MAX)) ? DUR_MAX : word_raw[DUR_W-1:0];

    always_comb begin
        if (!i_cfg.farnsworth_mode) begin
            gap_dur = dah_dur;
        end else if (i_cfg.farnsworth_gap > DUR_MAX) begin
            gap_dur = DUR_MAX;
        end else begin
            gap_dur = i_cfg.farnsworth_gap;
        end
    end

    always_comb begin
        seg_done = 1'b0;
        priority if (r_word) begin
            seg      = '{tone_on: 1'b0, duration: word_dur, last: 1'b1};
            seg_done = 1'b1;
        end else if (r_cnt == '0) begin
            seg      = '{tone_on: 1'b0, duration: gap_dur, last: 1'b1};
            seg_done = 1'b1;
        end else if (!r_space) begin
            seg = '{tone_on: 1'b1, duration: (r_bits[ELEM_W-1] ? dah_dur : dit_dur),
                    last: 1'b0};
        end else begin
            seg = '{tone_on: 1'b0, duration: dit_dur, last: 1'b0};
        end
    end

    assign out_free = !r_out_valid || i_pop;
    assign load     = !r_busy && !i_q_stat.empty;
    assign emit     = r_busy && out_free;
    assign o_q_pop  = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_space     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy  <= 1'b1;
                r_space <= 1'b0;
            end else if (emit) begin
                if (seg_done) begin
                    r_busy <= 1'b0;
                end
                r_space <= !r_space;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_desc.word;
            r_cnt  <= i_desc.count;
            r_bits <= i_desc.bits;
        end else if (emit && r_space) begin
            r_cnt  <= r_cnt - 1'b1;
            r_bits <= r_bits << 1;
        end
        if (emit) begin
            r_out <= seg;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: src/morse_element_sequencer_core.sv
// ----------------------------------------------------------------------------
// morse_element_sequencer_core
// Turns packed Morse characters into timed tone and silence segments.
// ----------------------------------------------------------------------------
// Input channel: push an item (func, code) while full is low. Result channel:
// a segment (tone_on, duration, last) is valid while empty is low and is
// taken with pop; last marks the final segment of an item.
// Configuration: write dit_length, farnsworth_mode or farnsworth_gap through
// the cfg channel, ready is always high; writes only while the block is idle.
// Path: the first segment of an item passes the front register, the queue,
// the back part's item registers and its output register. A code item with n
// elements gives 2n+1 segments, a word space one; the back part emits one
// segment per cycle unless the receiver stalls, and none while loading an item.
// A front register and a descriptor queue of QUEUE_DEPTH entries decouple the
// input from the segment sequencer, which sets the rate.
// Reset: registers return to 100 ms dit, Farnsworth off, 720 ms gap; queues
// are emptied. A stalled receiver holds the segment on the ports; the front
// keeps accepting until the queue and front register fill, then full rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module morse_element_sequencer_core import mes_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire t_in_item             i_item,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output t_out_item                 o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    desc_valid;
    t_desc   front_desc;
    t_desc   q_desc;
    t_q_stat q_stat;
    logic    q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dit_length      <= DIT_LENGTH_RST;
            r_cfg.farnsworth_mode <= FARNSWORTH_MODE_RST;
            r_cfg.farnsworth_gap  <= FARNSWORTH_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIT_LENGTH:      r_cfg.dit_length      <= i_cfg_data[DIT_W-1:0];
                CFG_FARNSWORTH_MODE: r_cfg.farnsworth_mode <= i_cfg_data[0];
                CFG_FARNSWORTH_GAP:  r_cfg.farnsworth_gap  <= i_cfg_data[DUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mes_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_item       (i_item),
        .o_desc_valid (desc_valid),
        .o_desc       (front_desc),
        .i_q_full     (q_stat.full)
    );

    mes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_valid),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_desc  (q_desc),
        .o_stat  (q_stat)
    );

    mes_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_desc   (q_desc),
        .o_q_pop  (q_pop),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    `ASSERT_IMPLY(a_full_needs_queue_full, i_clk, i_rst_n, o_full, q_stat.full && desc_valid, "full raised while queue has room")
    `ASSERT_IMPLY(a_tone_not_last, i_clk, i_rst_n, !o_empty && o_result.tone_on, !o_result.last, "tone segment marked last")
    `ASSERT_IMPLY(a_dur_in_range, i_clk, i_rst_n, !o_empty, o_result.duration <= DUR_MAX, "segment duration above limit")

endmodule

`default_nettype wire
